[rtl/core/ccfb_feedback_packet_parser_assert.svh]
// assertion macros for the feedback packet parser
`ifndef CCFB_FEEDBACK_PACKET_PARSER_ASSERT_SVH
`define CCFB_FEEDBACK_PACKET_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CCFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccfb assertion failed");

// next-cycle implication
`define CCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccfb assertion failed");

`else

`define CCFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/ccfb_pkg.sv]
// types and constants shared by the feedback packet parser
package ccfb_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_BLOCK  = 3'd2,
    PH_METRIC = 3'd3,
    PH_PAD    = 3'd4,
    PH_STAMP  = 3'd5
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_STAMP  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_VERSION   = 3'd1,
    ERR_TYPE_FMT  = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_TRUNC     = 3'd4,
    ERR_OVERRUN   = 3'd5,
    ERR_RUN_WRAP  = 3'd6
  } err_e;

  // configuration register indexes
  localparam logic [1:0] CFG_VERSION     = 2'd0;
  localparam logic [1:0] CFG_PACKET_TYPE = 2'd1;
  localparam logic [1:0] CFG_FORMAT      = 2'd2;
  localparam logic [1:0] CFG_UNAVAIL     = 2'd3;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 13;

  // configuration reset values
  localparam logic [1:0]  RST_VERSION     = 2'd2;
  localparam logic [7:0]  RST_PACKET_TYPE = 8'd205;
  localparam logic [4:0]  RST_FORMAT      = 5'd11;
  localparam logic [12:0] RST_UNAVAIL     = 13'h1fff;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] ssrc;
    logic [15:0] sequence_res;
    logic        received;
    logic [1:0]  ecn;
    logic [12:0] arrival_offset;
    logic [31:0] report_time;
    logic        padding_flag;
    logic [15:0] length_words;
    err_e        error_code;
    logic        last;
  } result_t;

endpackage

[rtl/core/ccfb_feedback_packet_parser.sv]
// RTCP congestion-control feedback packet parser, one byte per transfer
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   input   | in        | in_valid_i / in_ready_o    | packet_byte_i, packet_start_i
//   result  | out       | out_valid_o / out_ready_i  | kind_o ... last_o
//   config  | in        | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while the result register is not stalled: a byte sits in the input register, is parsed
// by one pass of logic and its result (if any) lands in the result register.
// Reset returns the parser to waiting for a packet start and loads the
// default expected version, type, format and unavailable code.
// A stalled result register holds the parse stage; the input register takes
// one more byte only if it is empty, and ready stays low until the result goes.
`include "ccfb_feedback_packet_parser_assert.svh"

module ccfb_feedback_packet_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ccfb_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ccfb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     packet_byte_i,
  input  logic                           packet_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [31:0]                    ssrc_o,
  output logic [15:0]                    sequence_res_o,
  output logic                           received_o,
  output logic [1:0]                     ecn_o,
  output logic [12:0]                    arrival_offset_o,
  output logic [31:0]                    report_time_o,
  output logic                           padding_flag_o,
  output logic [15:0]                    length_words_o,
  output logic [2:0]                     error_code_o,
  output logic                           last_o
);
  import ccfb_pkg::*;

  // configuration registers
  logic [1:0]  exp_version_q;
  logic [7:0]  exp_type_q;
  logic [4:0]  exp_format_q;
  logic [12:0] unavail_q;

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [16:0] units_q, units_d;
  logic [31:0] blk_ssrc_q, blk_ssrc_d;
  logic [15:0] begin_seq_q, begin_seq_d;
  logic [15:0] cur_seq_q, cur_seq_d;
  logic [16:0] metrics_q, metrics_d;
  logic        odd_q, odd_d;
  logic [7:0]  held_q, held_d;

  // result register
  logic        out_valid_q;
  result_t     res_q, res_d;
  logic        emit;

  logic        stage_fire;

  assign stage_fire = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || stage_fire;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= RST_VERSION;
      exp_type_q    <= RST_PACKET_TYPE;
      exp_format_q  <= RST_FORMAT;
      unavail_q     <= RST_UNAVAIL;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VERSION:     exp_version_q <= cfg_data_i[1:0];
        CFG_PACKET_TYPE: exp_type_q    <= cfg_data_i[7:0];
        CFG_FORMAT:      exp_format_q  <= cfg_data_i[4:0];
        CFG_UNAVAIL:     unavail_q     <= cfg_data_i[12:0];
        default:         ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= packet_byte_i;
      in_start_q <= packet_start_i;
    end
  end

  // byte parse
  always_comb begin
    logic [2:0]  pos;
    phase_e      phase;
    logic [31:0] fs;
    logic [15:0] diff;
    logic [16:0] run;
    logic [16:0] units_sub;
    logic [16:0] units_hdr;
    logic [16:0] units_dec;
    logic [16:0] metrics_dec;
    logic [12:0] code;
    logic        rcv;
    logic        err;
    err_e        err_code;

    phase_d     = phase_q;
    pos_d       = pos_q;
    units_d     = units_q;
    blk_ssrc_d  = blk_ssrc_q;
    begin_seq_d = begin_seq_q;
    cur_seq_d   = cur_seq_q;
    metrics_d   = metrics_q;
    odd_d       = odd_q;
    held_d      = held_q;
    res_d       = '0;
    emit        = 1'b0;
    err         = 1'b0;
    err_code    = ERR_NONE;

    // packet start restarts the header
    phase = in_start_q ? PH_HEADER : phase_q;
    pos   = in_start_q ? 3'd0 : pos_q;
    fs    = {(in_start_q ? 24'd0 : shift_q[23:0]), in_byte_q};
    if (in_start_q) begin
      phase_d = PH_HEADER;
    end
    shift_d = fs;

    diff        = fs[15:0] - begin_seq_q;
    run         = {1'b0, diff} + 17'd1;
    units_sub   = units_q - 17'd4;
    units_hdr   = {begin_seq_q - 16'd2, 1'b0};
    units_dec   = units_q - 17'd1;
    metrics_dec = metrics_q - 17'd1;
    code        = {held_q[4:0], in_byte_q};
    rcv         = held_q[7] && (code != unavail_q);

    case (phase)
      PH_HEADER: begin
        pos_d = pos + 3'd1;
        if (pos == 3'd0) begin
          held_d = in_byte_q;
        end else if (pos == 3'd1) begin
          if (held_q[7:6] != exp_version_q) begin
            err      = 1'b1;
            err_code = ERR_VERSION;
          end else if (held_q[4:0] != exp_format_q || in_byte_q != exp_type_q) begin
            err      = 1'b1;
            err_code = ERR_TYPE_FMT;
          end
        end else if (pos == 3'd3) begin
          begin_seq_d = fs[15:0];
        end else if (pos == 3'd7) begin
          if (begin_seq_q < 16'd2) begin
            err      = 1'b1;
            err_code = ERR_LENGTH;
          end else begin
            emit               = 1'b1;
            res_d.kind         = KIND_HEADER;
            res_d.ssrc         = fs;
            res_d.padding_flag = held_q[5];
            res_d.length_words = begin_seq_q;
            units_d            = units_hdr;
            phase_d            = (units_hdr == 17'd0) ? PH_STAMP : PH_BLOCK;
            pos_d              = 3'd0;
            shift_d            = '0;
          end
        end
      end

      PH_BLOCK: begin
        pos_d = pos + 3'd1;
        if (pos == 3'd0 && units_q < 17'd4) begin
          err      = 1'b1;
          err_code = ERR_TRUNC;
        end else if (pos == 3'd3) begin
          blk_ssrc_d = fs;
        end else if (pos == 3'd5) begin
          begin_seq_d = fs[15:0];
        end else if (pos == 3'd7) begin
          units_d = units_sub;
          if (run[16]) begin
            err      = 1'b1;
            err_code = ERR_RUN_WRAP;
          end else if ({1'b0, units_sub} < ({1'b0, run} + {17'd0, run[0]})) begin
            err      = 1'b1;
            err_code = ERR_OVERRUN;
          end else begin
            metrics_d = run;
            odd_d     = run[0];
            cur_seq_d = begin_seq_q;
            phase_d   = PH_METRIC;
            pos_d     = 3'd0;
          end
        end
      end

      PH_METRIC: begin
        if (pos == 3'd0) begin
          held_d = in_byte_q;
          pos_d  = 3'd1;
        end else begin
          emit               = 1'b1;
          res_d.kind         = KIND_ENTRY;
          res_d.ssrc         = blk_ssrc_q;
          res_d.sequence_res = cur_seq_q;
          if (rcv) begin
            res_d.received       = 1'b1;
            res_d.ecn            = held_q[6:5];
            res_d.arrival_offset = code;
          end
          cur_seq_d = cur_seq_q + 16'd1;
          metrics_d = metrics_dec;
          units_d   = units_dec;
          pos_d     = 3'd0;
          if (metrics_dec == 17'd0) begin
            if (odd_q) begin
              phase_d = PH_PAD;
            end else begin
              phase_d = (units_dec == 17'd0) ? PH_STAMP : PH_BLOCK;
              shift_d = '0;
            end
          end
        end
      end

      PH_PAD: begin
        if (pos == 3'd0) begin
          pos_d = 3'd1;
        end else begin
          units_d = units_dec;
          odd_d   = 1'b0;
          phase_d = (units_dec == 17'd0) ? PH_STAMP : PH_BLOCK;
          pos_d   = 3'd0;
          shift_d = '0;
        end
      end

      PH_STAMP: begin
        pos_d = pos + 3'd1;
        if (pos == 3'd3) begin
          emit              = 1'b1;
          res_d.kind        = KIND_STAMP;
          res_d.report_time = fs;
          res_d.last        = 1'b1;
          phase_d           = PH_IDLE;
          pos_d             = 3'd0;
        end
      end

      default: begin
        phase_d = PH_IDLE;
        pos_d   = 3'd0;
      end
    endcase

    // error result ends the packet
    if (err) begin
      emit             = 1'b1;
      res_d            = '0;
      res_d.kind       = KIND_ERROR;
      res_d.error_code = err_code;
      res_d.last       = 1'b1;
      phase_d          = PH_IDLE;
      pos_d            = 3'd0;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      shift_q     <= '0;
      units_q     <= '0;
      blk_ssrc_q  <= '0;
      begin_seq_q <= '0;
      cur_seq_q   <= '0;
      metrics_q   <= '0;
      odd_q       <= 1'b0;
      held_q      <= '0;
    end else if (stage_fire) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      shift_q     <= shift_d;
      units_q     <= units_d;
      blk_ssrc_q  <= blk_ssrc_d;
      begin_seq_q <= begin_seq_d;
      cur_seq_q   <= cur_seq_d;
      metrics_q   <= metrics_d;
      odd_q       <= odd_d;
      held_q      <= held_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (stage_fire && emit) begin
      res_q <= res_d;
    end
  end

  // outputs
  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_q.kind;
  assign ssrc_o           = res_q.ssrc;
  assign sequence_res_o   = res_q.sequence_res;
  assign received_o       = res_q.received;
  assign ecn_o            = res_q.ecn;
  assign arrival_offset_o = res_q.arrival_offset;
  assign report_time_o    = res_q.report_time;
  assign padding_flag_o   = res_q.padding_flag;
  assign length_words_o   = res_q.length_words;
  assign error_code_o     = res_q.error_code;
  assign last_o           = res_q.last;

  // checks
  `CCFB_ASSERT_IMPL(a_metric_count, clk_i, rst_ni, phase_q == PH_METRIC, metrics_q != 17'd0)
  `CCFB_ASSERT_IMPL(a_pad_pending, clk_i, rst_ni, phase_q == PH_PAD, odd_q)
  `CCFB_ASSERT_IMPL(a_units_cover, clk_i, rst_ni, phase_q == PH_METRIC, units_q >= metrics_q)
  `CCFB_ASSERT_IMPL(a_last_kind, clk_i, rst_ni, out_valid_q && res_q.last, res_q.kind == KIND_STAMP || res_q.kind == KIND_ERROR)
  `CCFB_ASSERT_NEXT(a_no_result, clk_i, rst_ni, stage_fire && !emit, !out_valid_q)

endmodule
